>>> design/tsg_pkg.sv
// Shared constants, types and codes of the triangle span generator.
package tsg_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int SCR_W      = 11;
  localparam int COLOR_W    = 16;

  localparam logic [SCR_W-1:0] RESET_WIDTH  = SCR_W'(800);
  localparam logic [SCR_W-1:0] RESET_HEIGHT = SCR_W'(480);

  // coordinate difference, product of two differences
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;

  // divider dividend magnitude covers both dx * 2^F and the split product
  localparam int DIV_W = (COORD_BITS + FRAC_BITS > 2 * COORD_BITS) ?
                         (COORD_BITS + FRAC_BITS) : (2 * COORD_BITS);
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam int SLOPE_W = COORD_BITS + FRAC_BITS + 1;
  localparam int EDGE_W  = COORD_BITS + FRAC_BITS + 2;
  localparam int CMP_W   = ((COORD_BITS > SCR_W) ? COORD_BITS : SCR_W) + 2;

  localparam int IN_FIELDS_W  = 6 * COORD_BITS + COLOR_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 3 * SCR_W + COLOR_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // input item kind (tuser)
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  // configuration register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TOP,
    PH_BOTH,
    PH_BOT
  } walk_phase_t;

  typedef enum logic [2:0] {
    DS_SPLIT,
    DS_SLOPE0,
    DS_SLOPE1,
    DS_SLOPE2,
    DS_SLOPE3
  } div_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_MUL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SPAN
  } ctrl_state_t;

  typedef struct packed {
    logic     capture;
    logic     setup;
    logic     mul;
    logic     div_start;
    logic     div_store;
    div_sel_t sel;
    logic     span_go;
  } dp_cmd_t;

  typedef struct packed {
    logic general;
    logic walk_idle;
    logic out_free;
    logic div_done;
  } dp_status_t;

endpackage

>>> design/tsg_div.sv
// Restoring divider, one quotient bit per cycle, sign and magnitude operands.
module tsg_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              num_neg,
  input  logic [tsg_pkg::DIV_W-1:0]         num_mag,
  input  logic [tsg_pkg::COORD_BITS-1:0]    den,
  output logic                              done,
  output logic                              quo_neg,
  output logic [tsg_pkg::DIV_W-1:0]         quo_mag
);
  import tsg_pkg::*;

  logic                    busy_r;
  logic                    done_r;
  logic [DIV_CNT_W-1:0]    cnt_r;
  logic [COORD_BITS:0]     rem_r;
  logic [DIV_W-1:0]        quo_r;
  logic [COORD_BITS-1:0]   den_r;
  logic                    neg_r;
  logic [COORD_BITS:0]     shifted;
  logic                    fits;

  assign shifted = {rem_r[COORD_BITS-1:0], quo_r[DIV_W-1]};
  assign fits    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num_mag;
      den_r <= den;
      neg_r <= num_neg;
    end else if (busy_r) begin
      rem_r <= fits ? (shifted - {1'b0, den_r}) : shifted;
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  assign done    = done_r;
  assign quo_neg = neg_r;
  // a zero divisor yields a zero quotient
  assign quo_mag = (den_r == '0) ? '0 : quo_r;

endmodule

>>> design/tsg_datapath.sv
// Datapath: vertex sort, split and slope setup, edge walk, span clip, output stage.
module tsg_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tsg_pkg::dp_cmd_t                  cmd,
  output tsg_pkg::dp_status_t               status,
  input  logic [tsg_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                              cfg_valid,
  input  logic                              cfg_index,
  input  logic [tsg_pkg::SCR_W-1:0]         cfg_data,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic [tsg_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tuser,
  output logic                              out_tlast
);
  import tsg_pkg::*;

  function automatic logic signed [DIFF_W-1:0] sdiff(input coord_t a, input coord_t b);
    return {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
  endfunction

  function automatic logic signed [EDGE_W-1:0] to_fixed(input coord_t c);
    return {{(EDGE_W-COORD_BITS-FRAC_BITS){c[COORD_BITS-1]}}, c, {FRAC_BITS{1'b0}}};
  endfunction

  // whole column of an edge, truncated toward zero
  function automatic logic signed [CMP_W-1:0] edge_col(input logic signed [EDGE_W-1:0] pos);
    logic signed [EDGE_W-1:0]          adj;
    logic signed [EDGE_W-FRAC_BITS-1:0] whole;
    adj   = pos[EDGE_W-1] ? (pos + EDGE_W'((1 << FRAC_BITS) - 1)) : pos;
    whole = adj[EDGE_W-1:FRAC_BITS];
    return CMP_W'(whole);
  endfunction

  // unpacked input vertices
  coord_t v0x, v0y, v1x, v1y, v2x, v2y;
  coord_t sax, say, sbx, sby, scx, scy;

  assign v0x = in_tdata[0*COORD_BITS +: COORD_BITS];
  assign v0y = in_tdata[1*COORD_BITS +: COORD_BITS];
  assign v1x = in_tdata[2*COORD_BITS +: COORD_BITS];
  assign v1y = in_tdata[3*COORD_BITS +: COORD_BITS];
  assign v2x = in_tdata[4*COORD_BITS +: COORD_BITS];
  assign v2y = in_tdata[5*COORD_BITS +: COORD_BITS];

  always_comb begin : sort
    coord_t tx, ty;
    tx  = '0;
    ty  = '0;
    sax = v0x; say = v0y;
    sbx = v1x; sby = v1y;
    scx = v2x; scy = v2y;
    if (sby < say) begin
      tx = sax; ty = say; sax = sbx; say = sby; sbx = tx; sby = ty;
    end
    if (scy < say) begin
      tx = sax; ty = say; sax = scx; say = scy; scx = tx; scy = ty;
    end
    if (scy < sby) begin
      tx = sbx; ty = sby; sbx = scx; sby = scy; scx = tx; scy = ty;
    end
  end

  coord_t                     ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  coord_t                     split_r;
  logic [COLOR_W-1:0]         color_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [SLOPE_W-1:0]  slope_r [4];
  walk_phase_t                phase_r;
  coord_t                     row_r;
  logic signed [EDGE_W-1:0]   edge_a_r, edge_b_r;
  logic [SCR_W-1:0]           width_r, height_r;

  logic flat_bot, flat_top;
  assign flat_bot = (by_r == cy_r);
  assign flat_top = !flat_bot && (ay_r == by_r);

  // divider operands
  logic signed [DIFF_W-1:0] slope_dx, slope_dy, dx_abs;
  logic [PROD_W-1:0]        prod_abs;
  logic                     div_neg;
  logic [DIV_W-1:0]         div_mag;
  logic [COORD_BITS-1:0]    div_den;
  logic                     div_done, quo_neg;
  logic [DIV_W-1:0]         quo_mag;

  always_comb begin
    case (cmd.sel)
      DS_SLOPE0: begin slope_dx = sdiff(bx_r, ax_r);    slope_dy = sdiff(by_r, ay_r); end
      DS_SLOPE1: begin slope_dx = sdiff(split_r, ax_r); slope_dy = sdiff(by_r, ay_r); end
      DS_SLOPE2: begin
        slope_dx = flat_top ? sdiff(cx_r, ax_r) : sdiff(cx_r, bx_r);
        slope_dy = sdiff(cy_r, by_r);
      end
      DS_SLOPE3: begin slope_dx = sdiff(cx_r, split_r); slope_dy = sdiff(cy_r, by_r); end
      default:   begin slope_dx = '0;                   slope_dy = sdiff(cy_r, ay_r); end
    endcase
  end

  assign dx_abs   = slope_dx[DIFF_W-1] ? -slope_dx : slope_dx;
  assign prod_abs = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);

  always_comb begin
    div_den = slope_dy[COORD_BITS-1:0];
    if (cmd.sel == DS_SPLIT) begin
      div_neg = prod_r[PROD_W-1];
      div_mag = DIV_W'(prod_abs[2*COORD_BITS-1:0]);
    end else begin
      div_neg = slope_dx[DIFF_W-1];
      div_mag = DIV_W'({dx_abs[COORD_BITS-1:0], {FRAC_BITS{1'b0}}});
    end
  end

  tsg_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .num_neg (div_neg),
    .num_mag (div_mag),
    .den     (div_den),
    .done    (div_done),
    .quo_neg (quo_neg),
    .quo_mag (quo_mag)
  );

  logic signed [SLOPE_W-1:0]  quo_slope_mag, quo_slope;
  logic signed [DIFF_W-1:0]   quo_col_mag, quo_col;
  coord_t                     split_new;

  assign quo_slope_mag = SLOPE_W'(quo_mag[COORD_BITS+FRAC_BITS-1:0]);
  assign quo_slope     = quo_neg ? -quo_slope_mag : quo_slope_mag;
  assign quo_col_mag   = DIFF_W'(quo_mag[COORD_BITS-1:0]);
  assign quo_col       = quo_neg ? -quo_col_mag : quo_col_mag;
  assign split_new     = COORD_BITS'(sdiff(ax_r, coord_t'(0)) + quo_col);

  // span of the current row
  logic signed [CMP_W-1:0] col_a, col_b, lo, hi, row_ext, w_ext, h_ext, lo_c, hi_c;
  logic                    row_vis, span_vis, at_mid;

  assign col_a   = edge_col(edge_a_r);
  assign col_b   = edge_col(edge_b_r);
  assign lo      = (col_a > col_b) ? col_b : col_a;
  assign hi      = (col_a > col_b) ? col_a : col_b;
  assign row_ext = CMP_W'(row_r);
  assign w_ext   = signed'(CMP_W'(width_r));
  assign h_ext   = signed'(CMP_W'(height_r));
  assign row_vis = (row_ext >= 0) && (row_ext < h_ext);
  assign span_vis = row_vis && !(hi < 0) && !(lo >= w_ext);
  assign lo_c    = (lo < 0) ? '0 : lo;
  assign hi_c    = (hi >= w_ext) ? (w_ext - 1'b1) : hi;
  assign at_mid  = (row_r == by_r);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RESET_WIDTH;
      height_r <= RESET_HEIGHT;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  // walk phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (cmd.setup) begin
      if (flat_bot) begin
        phase_r <= PH_TOP;
      end else if (flat_top) begin
        phase_r <= PH_BOT;
      end else begin
        phase_r <= PH_BOTH;
      end
    end else if (cmd.span_go && at_mid) begin
      phase_r <= (phase_r == PH_BOTH) ? PH_BOT : PH_IDLE;
    end
  end

  // triangle registers and edge walk
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ax_r    <= sax; ay_r <= say;
      bx_r    <= sbx; by_r <= sby;
      cx_r    <= scx; cy_r <= scy;
      color_r <= in_tdata[6*COORD_BITS +: COLOR_W];
    end
    if (cmd.mul) begin
      prod_r <= sdiff(by_r, ay_r) * sdiff(cx_r, ax_r);
    end
    if (cmd.setup) begin
      if (flat_bot) begin
        split_r  <= cx_r;
        row_r    <= ay_r;
        edge_a_r <= to_fixed(ax_r);
        edge_b_r <= to_fixed(ax_r);
      end else if (flat_top) begin
        split_r  <= bx_r;
        row_r    <= cy_r;
        edge_a_r <= to_fixed(cx_r);
        edge_b_r <= to_fixed(cx_r);
      end else begin
        row_r    <= ay_r;
        edge_a_r <= to_fixed(ax_r);
        edge_b_r <= to_fixed(ax_r);
      end
    end else if (cmd.span_go) begin
      if (at_mid) begin
        if (phase_r == PH_BOTH) begin
          row_r    <= cy_r;
          edge_a_r <= to_fixed(cx_r);
          edge_b_r <= to_fixed(cx_r);
        end
      end else if (phase_r == PH_BOT) begin
        row_r    <= row_r - coord_t'(1);
        edge_a_r <= edge_a_r - EDGE_W'(slope_r[2]);
        edge_b_r <= edge_b_r - EDGE_W'(slope_r[3]);
      end else begin
        row_r    <= row_r + coord_t'(1);
        edge_a_r <= edge_a_r + EDGE_W'(slope_r[0]);
        edge_b_r <= edge_b_r + EDGE_W'(slope_r[1]);
      end
    end
    if (cmd.div_store) begin
      case (cmd.sel)
        DS_SPLIT:  split_r    <= split_new;
        DS_SLOPE0: slope_r[0] <= quo_slope;
        DS_SLOPE1: slope_r[1] <= quo_slope;
        DS_SLOPE2: slope_r[2] <= quo_slope;
        DS_SLOPE3: slope_r[3] <= quo_slope;
        default:   ;
      endcase
    end
  end

  // output stage
  logic              out_valid_r;
  logic [SCR_W-1:0]  out_row_r, out_start_r, out_end_r;
  logic [COLOR_W-1:0] out_color_r;
  logic              out_vis_r, out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.span_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.span_go) begin
      out_row_r   <= span_vis ? row_ext[SCR_W-1:0] : '0;
      out_start_r <= span_vis ? lo_c[SCR_W-1:0] : '0;
      out_end_r   <= span_vis ? hi_c[SCR_W-1:0] : '0;
      out_color_r <= color_r;
      out_vis_r   <= span_vis;
      out_last_r  <= at_mid && (phase_r != PH_BOTH);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}},
                       out_color_r, out_end_r, out_start_r, out_row_r};
  assign out_tuser  = out_vis_r;
  assign out_tlast  = out_last_r;

  assign status.general   = !flat_bot && !flat_top;
  assign status.walk_idle = (phase_r == PH_IDLE);
  assign status.out_free  = !out_valid_r || out_tready;
  assign status.div_done  = div_done;

endmodule

>>> design/tsg_ctrl.sv
// Controller: sequences triangle setup, slope divisions and span steps.
module tsg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_action,
  output logic                 in_tready,
  input  tsg_pkg::dp_status_t  status,
  output tsg_pkg::dp_cmd_t     cmd
);
  import tsg_pkg::*;

  ctrl_state_t state_r, state_nxt;
  div_sel_t    sel_r, sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= DS_SPLIT;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (in_action == ACT_LOAD) ? S_SETUP : S_SPAN;
        end
      end
      S_SETUP: begin
        state_nxt = status.general ? S_MUL : S_DIV_GO;
        sel_nxt   = status.general ? DS_SPLIT : DS_SLOPE0;
      end
      S_MUL:    state_nxt = S_DIV_GO;
      S_DIV_GO: state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (status.div_done) begin
          case (sel_r)
            DS_SPLIT:  begin sel_nxt = DS_SLOPE0; state_nxt = S_DIV_GO; end
            DS_SLOPE0: begin sel_nxt = DS_SLOPE1; state_nxt = S_DIV_GO; end
            DS_SLOPE1: begin sel_nxt = DS_SLOPE2; state_nxt = S_DIV_GO; end
            DS_SLOPE2: begin sel_nxt = DS_SLOPE3; state_nxt = S_DIV_GO; end
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_SPAN: begin
        if (status.walk_idle || status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    cmd.sel   = sel_r;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid && (in_action == ACT_LOAD);
      end
      S_SETUP:    cmd.setup     = 1'b1;
      S_MUL:      cmd.mul       = 1'b1;
      S_DIV_GO:   cmd.div_start = 1'b1;
      S_DIV_WAIT: cmd.div_store = status.div_done;
      S_SPAN:     cmd.span_go   = !status.walk_idle && status.out_free;
      default:    ;
    endcase
  end

endmodule

>>> design/triangle_scanline_span_generator.sv
// Top level of the triangle scanline span generator.
//
// A load item (tuser 0) carries three vertices and an RGB565 colour; the
// block sorts the vertices by row, splits the triangle at the middle vertex
// and works out the split column and four signed Q13.16 edge slopes on one
// shared restoring divider that retires a quotient bit per cycle. A load
// keeps the input closed until the last slope is stored, and when the
// triangle has neither a flat top nor a flat bottom the split column is
// divided out first. An advance item (tuser 1) is accepted and then, once
// the output register is free, the block clips the current row, loads the
// output register and steps both edge accumulators. Each advance on an
// active triangle gives one span: the top half downward to the middle row,
// then the bottom half upward from the lowest row to the middle row, so the
// middle row comes out twice when the triangle has both halves.
// Spans are ordered, clipped to the screen size set through the
// configuration port, and flagged not visible (row and columns zero) when
// the row or the whole span lies off screen; tlast marks the final span.
// A load replaces any walk in progress; an advance with no triangle gives
// nothing. The output register holds a span until it is taken, and the
// input stays open meanwhile, so a load may overlap a waiting span.
module triangle_scanline_span_generator (
  input  logic                             clk,
  input  logic                             rst_n,
  // input items
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [11:0] vertex0_x, [23:12] vertex0_y, [35:24] vertex1_x,
  // [47:36] vertex1_y, [59:48] vertex2_x, [71:60] vertex2_y,
  // [87:72] fill_color
  input  logic [tsg_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] action: 0 load a triangle, 1 request the next span
  input  logic                             in_tuser,
  // result items
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [10:0] span_row, [21:11] span_start, [32:22] span_end,
  // [48:33] span_color, [55:49] zero
  output logic [tsg_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [0] visible
  output logic                             out_tuser,
  // last span of the triangle
  output logic                             out_tlast,
  // configuration writes: index 0 screen_width, 1 screen_height
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [tsg_pkg::SCR_W-1:0]        cfg_data
);
  import tsg_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // registers accept a write in any cycle
  assign cfg_ready = 1'b1;

  tsg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_action (in_tuser),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  tsg_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> design/tsg_checker.sv
// Port checker for the span generator, bound to the top level.
module tsg_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tsg_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                             out_tuser,
  input logic                             out_tlast
);
  import tsg_pkg::*;

  // hold a stalled item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled span changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("span offered straight after reset");

  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[3*SCR_W-1:0] == '0)
    else $error("invisible span carries row or columns");

  a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[2*SCR_W-1:SCR_W] <= out_tdata[3*SCR_W-1:2*SCR_W])
    else $error("visible span start beyond end");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == ACT_LOAD) && !out_tvalid |=> !out_tvalid)
    else $error("load item produced a span");

endmodule

bind triangle_scanline_span_generator tsg_checker u_tsg_checker (.*);
